// ===== src/cmw_pkg.sv =====
// cmw_pkg: shared types and constants for the cbor map/text walker
// token kinds, header decode constants, result beat and stack command structs
// no dependencies
`default_nettype none

package cmw_pkg;

    // token kind codes carried on token_kind
    typedef enum logic [1:0] {
        TK_TEXT = 2'd0,
        TK_MAP  = 2'd1,
        TK_END  = 2'd2,
        TK_ERR  = 2'd3
    } token_kind_t;

    // major types accepted in an initial byte
    localparam logic [2:0] MAJOR_TEXT = 3'd3;
    localparam logic [2:0] MAJOR_MAP  = 3'd5;

    // additional info codes
    localparam logic [4:0] INFO_IMM_LIMIT = 5'd24;
    localparam logic [4:0] INFO_ARG8      = 5'd24;
    localparam logic [4:0] INFO_ARG16     = 5'd25;
    localparam logic [4:0] INFO_ARG32     = 5'd26;

    // number of argument bytes that follow the initial byte
    localparam logic [2:0] HDR_LEN8  = 3'd1;
    localparam logic [2:0] HDR_LEN16 = 3'd2;
    localparam logic [2:0] HDR_LEN32 = 3'd4;

    // result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_CNT_W = 3;

    // one result beat
    typedef struct packed {
        token_kind_t  kind;
        logic [31:0]  argument;
        logic [3:0]   nest_depth;
        logic [16:0]  payload_offset;
        logic         final_token;
    } result_t;

    // walker to stack: one push or one item completion per byte, plus buffer clear
    typedef struct packed {
        logic         push;
        logic         done;
        logic         clear;
        logic [32:0]  push_count;
    } stack_cmd_t;

endpackage

`default_nettype wire

// ===== src/cmw_stack.sv =====
// cmw_stack: open-map stack, one cell per level with its own decrement
// completion of an item pops every level that reaches zero in a single cycle
// depends on cmw_pkg
`default_nettype none

module cmw_stack #(
    parameter int MAX_DEPTH = 8
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  cmw_pkg::stack_cmd_t                   cmd,
    output logic [$clog2(MAX_DEPTH + 1) - 1:0]    level,
    output logic [$clog2(MAX_DEPTH + 1) - 1:0]    pop_level
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);

    logic [32:0]      entry_reg  [MAX_DEPTH];
    logic [32:0]      entry_next [MAX_DEPTH];
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    assign level = level_reg;

    // level left after an item completes: just above the highest open entry not at one
    always_comb
    begin
        pop_level = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if ((LVL_W'(i) < level_reg) && (entry_reg[i] != 33'd1))
            begin
                pop_level = LVL_W'(i + 1);
            end
        end
    end

    // per-cell update: load on push, decrement the surviving top on completion
    always_comb
    begin
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (cmd.push && (LVL_W'(i) == level_reg))
            begin
                entry_next[i] = cmd.push_count;
            end
            else if (cmd.done && (pop_level != '0) && (LVL_W'(i) == pop_level - LVL_W'(1)))
            begin
                entry_next[i] = entry_reg[i] - 33'd1;
            end
        end
    end

    // next stack level
    always_comb
    begin
        if (cmd.clear)
        begin
            level_next = '0;
        end
        else if (cmd.push)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (cmd.done)
        begin
            level_next = pop_level;
        end
        else
        begin
            level_next = level_reg;
        end
    end

    // level register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // cell storage, only levels below the stack level are ever looked at
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== src/cmw_walker.sv =====
// cmw_walker: per-byte header decode, payload skipping and token generation
// holds header accumulator, counters, offset and halt flag; drives the stack
// depends on cmw_pkg
`default_nettype none

module cmw_walker #(
    parameter int MAX_DEPTH = 8,
    parameter int MAX_BYTES = 65536
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   fire,
    input  wire  [7:0]                            data_byte,
    input  wire                                   is_last,
    input  wire                                   no_byte,
    input  wire  [$clog2(MAX_DEPTH + 1) - 1:0]    level,
    input  wire  [$clog2(MAX_DEPTH + 1) - 1:0]    pop_level,
    output cmw_pkg::stack_cmd_t                   cmd,
    output logic [1:0]                            res_cnt,
    output cmw_pkg::result_t                      res0,
    output cmw_pkg::result_t                      res1
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int OFF_W = $clog2(MAX_BYTES + 1);

    logic [31:0]      hdr_accum_reg, hdr_accum_next;
    logic [2:0]       hdr_left_reg, hdr_left_next;
    logic             hdr_kind_reg, hdr_kind_next;
    logic [31:0]      text_left_reg, text_left_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic             halted_reg, halted_next;

    // end of buffer beat: end of data when nothing is open, parse error otherwise
    function automatic cmw_pkg::result_t end_beat(
        input logic        clean,
        input logic [3:0]  depth,
        input logic [16:0] off
    );
        cmw_pkg::result_t r;
        r                = '0;
        r.kind           = clean ? cmw_pkg::TK_END : cmw_pkg::TK_ERR;
        r.nest_depth     = clean ? 4'd0 : depth;
        r.payload_offset = off;
        return r;
    endfunction

    // byte decode and token build
    always_comb
    begin
        logic [2:0]       major;
        logic [4:0]       info;
        logic [31:0]      accum_shift;
        logic [OFF_W-1:0] off_inc;
        logic [LVL_W-1:0] level_after;
        logic             err;
        logic             tok;
        logic             clr;
        logic             hdr_fin;
        logic             fin_map;
        logic [31:0]      fin_arg;
        logic             clean;

        major       = data_byte[7:5];
        info        = data_byte[4:0];
        accum_shift = {hdr_accum_reg[23:0], data_byte};
        off_inc     = offset_reg + OFF_W'(1);
        err         = 1'b0;
        tok         = 1'b0;
        clr         = 1'b0;
        hdr_fin     = 1'b0;
        fin_map     = 1'b0;
        fin_arg     = '0;
        clean       = 1'b0;
        level_after = level;

        hdr_accum_next = hdr_accum_reg;
        hdr_left_next  = hdr_left_reg;
        hdr_kind_next  = hdr_kind_reg;
        text_left_next = text_left_reg;
        offset_next    = offset_reg;
        halted_next    = halted_reg;
        cmd            = '0;
        res_cnt        = 2'd0;
        res0           = '0;
        res1           = '0;

        if (fire)
        begin
            if (no_byte)
            begin
                // empty item closes the buffer
                if (!halted_reg)
                begin
                    clean   = (hdr_left_reg == 3'd0) && (text_left_reg == 32'd0)
                              && (level == '0);
                    res0    = end_beat(clean, 4'(level), 17'(offset_reg));
                    res_cnt = 2'd1;
                end
                clr = 1'b1;
            end
            else if (halted_reg)
            begin
                clr = is_last;
            end
            else
            begin
                if (offset_reg >= OFF_W'(MAX_BYTES))
                begin
                    err = 1'b1;
                end
                else
                begin
                    offset_next = off_inc;
                    if (text_left_reg != 32'd0)
                    begin
                        // text payload byte
                        text_left_next = text_left_reg - 32'd1;
                        cmd.done       = (text_left_reg == 32'd1);
                    end
                    else if (hdr_left_reg != 3'd0)
                    begin
                        // big-endian argument byte
                        hdr_accum_next = accum_shift;
                        hdr_left_next  = hdr_left_reg - 3'd1;
                        if (hdr_left_reg == 3'd1)
                        begin
                            hdr_fin = 1'b1;
                            fin_arg = accum_shift;
                            fin_map = hdr_kind_reg;
                        end
                    end
                    else if ((major != cmw_pkg::MAJOR_TEXT) && (major != cmw_pkg::MAJOR_MAP))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        // initial byte of a text or map
                        hdr_kind_next  = (major == cmw_pkg::MAJOR_MAP);
                        hdr_accum_next = '0;
                        if (info < cmw_pkg::INFO_IMM_LIMIT)
                        begin
                            hdr_fin = 1'b1;
                            fin_arg = 32'(info);
                            fin_map = (major == cmw_pkg::MAJOR_MAP);
                        end
                        else if (info == cmw_pkg::INFO_ARG8)
                        begin
                            hdr_left_next = cmw_pkg::HDR_LEN8;
                        end
                        else if (info == cmw_pkg::INFO_ARG16)
                        begin
                            hdr_left_next = cmw_pkg::HDR_LEN16;
                        end
                        else if (info == cmw_pkg::INFO_ARG32)
                        begin
                            hdr_left_next = cmw_pkg::HDR_LEN32;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                end

                // completed header: open a map, start a text, or finish an empty item
                if (hdr_fin)
                begin
                    hdr_accum_next = '0;
                    if (fin_map && (fin_arg != 32'd0))
                    begin
                        if (level >= LVL_W'(MAX_DEPTH))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            cmd.push       = 1'b1;
                            cmd.push_count = {fin_arg, 1'b0};
                        end
                    end
                    else if (fin_arg != 32'd0)
                    begin
                        text_left_next = fin_arg;
                    end
                    else
                    begin
                        cmd.done = 1'b1;
                    end
                    if (!err)
                    begin
                        tok                 = 1'b1;
                        res0.kind           = fin_map ? cmw_pkg::TK_MAP : cmw_pkg::TK_TEXT;
                        res0.argument       = fin_arg;
                        res0.nest_depth     = 4'(level);
                        res0.payload_offset = 17'(off_inc);
                    end
                end

                // stack level once this byte is applied
                if (cmd.push)
                begin
                    level_after = level + LVL_W'(1);
                end
                else if (cmd.done)
                begin
                    level_after = pop_level;
                end

                if (err)
                begin
                    res0                = '0;
                    res0.kind           = cmw_pkg::TK_ERR;
                    res0.nest_depth     = 4'(level);
                    res0.payload_offset = 17'(offset_reg);
                    res_cnt             = 2'd1;
                    halted_next         = 1'b1;
                    clr                 = is_last;
                end
                else if (is_last)
                begin
                    clean = (hdr_left_next == 3'd0) && (text_left_next == 32'd0)
                            && (level_after == '0);
                    if (tok)
                    begin
                        res1    = end_beat(clean, 4'(level_after), 17'(offset_next));
                        res_cnt = 2'd2;
                    end
                    else
                    begin
                        res0    = end_beat(clean, 4'(level_after), 17'(offset_next));
                        res_cnt = 2'd1;
                    end
                    clr = 1'b1;
                end
                else
                begin
                    res_cnt = {1'b0, tok};
                end
            end

            // mark the last beat of this byte
            if (res_cnt == 2'd2)
            begin
                res1.final_token = 1'b1;
            end
            else if (res_cnt == 2'd1)
            begin
                res0.final_token = 1'b1;
            end

            // back to the idle walker state for the next buffer
            if (clr)
            begin
                hdr_accum_next = '0;
                hdr_left_next  = '0;
                hdr_kind_next  = 1'b0;
                text_left_next = '0;
                offset_next    = '0;
                halted_next    = 1'b0;
                cmd.clear      = 1'b1;
            end
        end
    end

    // walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_accum_reg <= '0;
            hdr_left_reg  <= '0;
            hdr_kind_reg  <= 1'b0;
            text_left_reg <= '0;
            offset_reg    <= '0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            hdr_accum_reg <= hdr_accum_next;
            hdr_left_reg  <= hdr_left_next;
            hdr_kind_reg  <= hdr_kind_next;
            text_left_reg <= text_left_next;
            offset_reg    <= offset_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/cmw_res_queue.sv =====
// cmw_res_queue: shifting result queue, takes up to two beats per cycle
// head slot drives the output port; room means two free slots
// depends on cmw_pkg
`default_nettype none

module cmw_res_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire  [1:0]         push_cnt,
    input  cmw_pkg::result_t   push0,
    input  cmw_pkg::result_t   push1,
    output logic               room,
    output logic               out_valid,
    input  wire                out_stall,
    output cmw_pkg::result_t   head
);

    localparam int DEPTH = cmw_pkg::RQ_DEPTH;
    localparam int CNT_W = cmw_pkg::RQ_CNT_W;

    cmw_pkg::result_t slot_reg  [DEPTH];
    cmw_pkg::result_t slot_next [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [CNT_W-1:0] cnt_base;

    assign out_valid = (count_reg != '0);
    assign head      = slot_reg[0];
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && !out_stall;
    assign cnt_base  = count_reg - CNT_W'(pop);

    // shift on pop, then drop new beats behind the remaining ones
    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            slot_next[i] = pop ? slot_reg[i + 1] : slot_reg[i];
        end
        slot_next[DEPTH-1] = slot_reg[DEPTH-1];
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((push_cnt != 2'd0) && (CNT_W'(i) == cnt_base))
            begin
                slot_next[i] = push0;
            end
            else if ((push_cnt == 2'd2) && (CNT_W'(i) == cnt_base + CNT_W'(1)))
            begin
                slot_next[i] = push1;
            end
        end
        count_next = cnt_base + CNT_W'(push_cnt);
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

// ===== src/cbor_map_text_walker.sv =====
// cbor_map_text_walker: streaming walker over text strings and maps, one byte a beat
// an accepted byte passes the input register and a queue slot before reaching the output
// throughput: one byte per cycle; a byte gives 0, 1 or 2 result beats, the result queue
// drains one beat per cycle unless stalled; input register holds under two free slots
// reset: asynchronous active low, clears walker state, stack level and queue; no sweep
// depends on cmw_pkg, cmw_stack, cmw_walker, cmw_res_queue
`default_nettype none

module cbor_map_text_walker #(
    parameter int MAX_DEPTH = 8,
    parameter int MAX_BYTES = 65536
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          in_valid,
    output logic         in_stall,
    input  wire  [7:0]   data_byte,
    input  wire          is_last,
    input  wire          no_byte,
    output logic         out_valid,
    input  wire          out_stall,
    output logic [1:0]   token_kind,
    output logic [31:0]  argument,
    output logic [3:0]   nest_depth,
    output logic [16:0]  payload_offset,
    output logic         final_token
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);

    logic                in_vld_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic                none_reg;
    logic                room;
    logic                fire;
    cmw_pkg::stack_cmd_t cmd;
    logic [LVL_W-1:0]    level;
    logic [LVL_W-1:0]    pop_level;
    logic [1:0]          res_cnt;
    cmw_pkg::result_t    res0;
    cmw_pkg::result_t    res1;
    cmw_pkg::result_t    head;

    // input register holds while the result queue is short of space
    assign fire     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= is_last;
            none_reg <= no_byte;
        end
    end

    cmw_walker #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_BYTES (MAX_BYTES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (byte_reg),
        .is_last   (last_reg),
        .no_byte   (none_reg),
        .level     (level),
        .pop_level (pop_level),
        .cmd       (cmd),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    cmw_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .level     (level),
        .pop_level (pop_level)
    );

    cmw_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // output beat fields
    assign token_kind     = head.kind;
    assign argument       = head.argument;
    assign nest_depth     = head.nest_depth;
    assign payload_offset = head.payload_offset;
    assign final_token    = head.final_token;

`ifndef SYNTHESIS
    // results only come from a processed byte
    a_res_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt != 2'd0) |-> fire)
        else $error("result beat without a processed byte");

    // a pair of beats is a header token followed by end of data or an error
    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt == 2'd2) |-> (res1.final_token && !res0.final_token
            && (res1.kind == cmw_pkg::TK_END || res1.kind == cmw_pkg::TK_ERR)
            && (res0.kind == cmw_pkg::TK_TEXT || res0.kind == cmw_pkg::TK_MAP)))
        else $error("bad two-beat result");

    // end of data only with every map closed
    a_end_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt != 2'd0 && res0.kind == cmw_pkg::TK_END)
            |-> (res0.nest_depth == 4'd0 && res0.argument == 32'd0))
        else $error("end of data with open nesting");

    // stack never grows past its depth
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (level < LVL_W'(MAX_DEPTH)))
        else $error("push beyond stack depth");
`endif

endmodule

`default_nettype wire
